FILE: rtl/core/c2p_pkg.sv
// Shared constants and helpers for the CAHV to pinhole conversion pipeline.
package c2p_pkg;

  localparam int CoordWidthDefault = 32;

  // Configuration register indexes
  localparam logic RegImageColumns = 1'b0;
  localparam logic RegImageRows    = 1'b1;

  localparam logic [15:0] ImageColumnsReset = 16'd1024;
  localparam logic [15:0] ImageRowsReset    = 16'd1024;

  localparam int SqrtSteps   = 32;
  localparam int CordicSteps = 32;
  localparam int DivSteps    = 33;
  localparam int NormMsb     = 40;

  localparam logic [30:0] PiQ329 = 31'd1686629713;

  // atan(2^-i) in Q.32
  function automatic logic [31:0] atan_step(input int i);
    logic [31:0] t;
    case (i)
      0:       t = 32'd3373259426;
      1:       t = 32'd1991351318;
      2:       t = 32'd1052175346;
      3:       t = 32'd534100635;
      4:       t = 32'd268086748;
      5:       t = 32'd134174063;
      6:       t = 32'd67103403;
      7:       t = 32'd33553749;
      8:       t = 32'd16777131;
      9:       t = 32'd8388597;
      10:      t = 32'd4194303;
      11:      t = 32'd2097152;
      default: t = 32'd1 << (32 - i);
    endcase
    return t;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
    logic signed [31:0] r;
    if (v > 40'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -40'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

FILE: rtl/core/cahv_to_pinhole_convert.sv
// CAHV camera model to pinhole parameters, fully pipelined.
//
// Usage: drive the nine A/H/V components and pulse start; busy is always low,
// so a new camera model may be issued every cycle. Each request yields one
// result marked by done_o for a single cycle, after passing through the
// registered chain: input register, products, rounding, squares, sum, 32
// square root stages, a setup stage, 33 parallel CORDIC / divider stages and
// an output register. One request per cycle is sustained.
// The APB port holds image_columns (0x0) and image_rows (0x4); write them
// only while no request is in flight. Reset clears the valid chain and
// loads both registers with 1024; payload registers are not reset.
// The receiver cannot stall: a result is shown for exactly one cycle.
// Scales are |AxH|, |AxV|; centers A.H, A.V; FOV = 2*atan2(count, 2*scale)
// via vectoring CORDIC; plane axes (H - hc*A)/hs and (V - vc*A)/vs with
// rounding division. Zero scale gives zero axes and FOV pi (0 if count is 0).
module cahv_to_pinhole_convert #(
  parameter int COORD_WIDTH = c2p_pkg::CoordWidthDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] axis_x_i,
  input  logic signed [31:0] axis_y_i,
  input  logic signed [31:0] axis_z_i,
  input  logic signed [31:0] horiz_x_i,
  input  logic signed [31:0] horiz_y_i,
  input  logic signed [31:0] horiz_z_i,
  input  logic signed [31:0] vert_x_i,
  input  logic signed [31:0] vert_y_i,
  input  logic signed [31:0] vert_z_i,
  output logic               done_o,
  output logic [31:0]        horiz_scale_o,
  output logic [31:0]        vert_scale_o,
  output logic signed [31:0] center_col_o,
  output logic signed [31:0] center_row_o,
  output logic [30:0]        fov_horiz_o,
  output logic [30:0]        fov_vert_o,
  output logic signed [31:0] plane_x_0_o,
  output logic signed [31:0] plane_x_1_o,
  output logic signed [31:0] plane_x_2_o,
  output logic signed [31:0] plane_y_0_o,
  output logic signed [31:0] plane_y_1_o,
  output logic signed [31:0] plane_y_2_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import c2p_pkg::*;

  localparam int CoordBits = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;
  localparam int Latency   = 5 + SqrtSteps + 1 + DivSteps + 1;

  // ---------------- configuration ----------------
  logic [15:0] cols_q, rows_q;
  logic        cfg_wr;
  logic        cfg_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_sel = paddr[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q <= ImageColumnsReset;
      rows_q <= ImageRowsReset;
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        RegImageColumns: cols_q <= pwdata[15:0];
        RegImageRows:    rows_q <= pwdata[15:0];
        default:         ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      RegImageColumns: prdata = {16'd0, cols_q};
      RegImageRows:    prdata = {16'd0, rows_q};
      default:         prdata = '0;
    endcase
  end

  assign busy = 1'b0;

  // ---------------- stage 1: capture ----------------
  logic [31:0] raw [9];
  assign raw[0] = axis_x_i;
  assign raw[1] = axis_y_i;
  assign raw[2] = axis_z_i;
  assign raw[3] = horiz_x_i;
  assign raw[4] = horiz_y_i;
  assign raw[5] = horiz_z_i;
  assign raw[6] = vert_x_i;
  assign raw[7] = vert_y_i;
  assign raw[8] = vert_z_i;

  logic              v1_q, v2_q, v3_q, v4_q;
  logic signed [31:0] a1_q [3];
  logic signed [31:0] hv1_q [2][3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= start & ~busy;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < 3; j++) begin
      a1_q[j]     <= 32'(signed'(raw[j][CoordBits-1:0]));
      hv1_q[0][j] <= 32'(signed'(raw[3+j][CoordBits-1:0]));
      hv1_q[1][j] <= 32'(signed'(raw[6+j][CoordBits-1:0]));
    end
  end

  // ---------------- stage 2: products ----------------
  logic signed [63:0] pc2_q [2][3][2];   // cross terms, positive and negative
  logic signed [63:0] pd2_q [2][3];      // dot terms
  logic signed [31:0] a2_q  [3];
  logic signed [31:0] hv2_q [2][3];

  always_ff @(posedge clk_i) begin
    for (int s = 0; s < 2; s++) begin
      for (int j = 0; j < 3; j++) begin
        pc2_q[s][j][0] <= a1_q[(j+1)%3] * hv1_q[s][(j+2)%3];
        pc2_q[s][j][1] <= a1_q[(j+2)%3] * hv1_q[s][(j+1)%3];
        pd2_q[s][j]    <= a1_q[j] * hv1_q[s][j];
        hv2_q[s][j]    <= hv1_q[s][j];
      end
    end
    a2_q <= a1_q;
  end

  // ---------------- stage 3: round to Q16.16 ----------------
  logic signed [35:0] c3_q   [2][3];
  logic signed [31:0] ctr3_q [2];
  logic signed [31:0] a3_q   [3];
  logic signed [31:0] hv3_q  [2][3];

  always_ff @(posedge clk_i) begin
    for (int s = 0; s < 2; s++) begin
      for (int j = 0; j < 3; j++) begin
        c3_q[s][j] <= 36'((66'(pc2_q[s][j][0]) - 66'(pc2_q[s][j][1])
                          + 66'sd536870912) >>> 30);
      end
      ctr3_q[s] <= sat32(40'((67'(pd2_q[s][0]) + 67'(pd2_q[s][1]) + 67'(pd2_q[s][2])
                              + 67'sd536870912) >>> 30));
    end
    a3_q  <= a2_q;
    hv3_q <= hv2_q;
  end

  // ---------------- stage 4: squares, center*A ----------------
  logic [63:0]        sq4_q  [2][3];
  logic               big4_q [2][3];
  logic signed [63:0] ca4_q  [2][3];
  logic signed [31:0] ctr4_q [2];
  logic signed [31:0] hv4_q  [2][3];
  logic [35:0]        cabs   [2][3];

  always_comb begin
    for (int s = 0; s < 2; s++) begin
      for (int j = 0; j < 3; j++) begin
        cabs[s][j] = c3_q[s][j][35] ? 36'(-c3_q[s][j]) : 36'(c3_q[s][j]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int s = 0; s < 2; s++) begin
      for (int j = 0; j < 3; j++) begin
        sq4_q[s][j]  <= cabs[s][j][31:0] * cabs[s][j][31:0];
        big4_q[s][j] <= |cabs[s][j][35:32];
        ca4_q[s][j]  <= ctr3_q[s] * a3_q[j];
      end
    end
    ctr4_q <= ctr3_q;
    hv4_q  <= hv3_q;
  end

  // ---------------- stage 5 and square root chain ----------------
  logic               sv_q   [SqrtSteps+1];
  logic [63:0]        sn_q   [SqrtSteps+1][2];
  logic [63:0]        sr_q   [SqrtSteps+1][2];
  logic               ssat_q [SqrtSteps+1][2];
  logic signed [31:0] sctr_q [SqrtSteps+1][2];
  logic [63:0]        smag_q [SqrtSteps+1][2][3];
  logic               sneg_q [SqrtSteps+1][2][3];

  logic [65:0]        sum5 [2];
  logic signed [64:0] num5 [2][3];

  always_comb begin
    for (int s = 0; s < 2; s++) begin
      sum5[s] = 66'(sq4_q[s][0]) + 66'(sq4_q[s][1]) + 66'(sq4_q[s][2]);
      for (int j = 0; j < 3; j++) begin
        num5[s][j] = (65'(hv4_q[s][j]) <<< 30) - 65'(ca4_q[s][j]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sv_q[0] <= 1'b0;
    end else begin
      sv_q[0] <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int s = 0; s < 2; s++) begin
      sn_q[0][s]   <= sum5[s][63:0];
      sr_q[0][s]   <= '0;
      ssat_q[0][s] <= big4_q[s][0] | big4_q[s][1] | big4_q[s][2] | (|sum5[s][65:64]);
      sctr_q[0][s] <= ctr4_q[s];
      for (int j = 0; j < 3; j++) begin
        smag_q[0][s][j] <= num5[s][j][64] ? 64'(-num5[s][j]) : 64'(num5[s][j]);
        sneg_q[0][s][j] <= num5[s][j][64];
      end
    end
  end

  for (genvar k = 0; k < SqrtSteps; k++) begin : g_sqrt
    localparam logic [63:0] Bit = 64'd1 << (62 - 2 * k);
    logic [64:0] trial [2];

    always_comb begin
      for (int s = 0; s < 2; s++) begin
        trial[s] = 65'(sr_q[k][s]) + 65'(Bit);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sv_q[k+1] <= 1'b0;
      end else begin
        sv_q[k+1] <= sv_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      for (int s = 0; s < 2; s++) begin
        if (65'(sn_q[k][s]) >= trial[s]) begin
          sn_q[k+1][s] <= sn_q[k][s] - trial[s][63:0];
          sr_q[k+1][s] <= (sr_q[k][s] >> 1) + Bit;
        end else begin
          sn_q[k+1][s] <= sn_q[k][s];
          sr_q[k+1][s] <= sr_q[k][s] >> 1;
        end
      end
      ssat_q[k+1] <= ssat_q[k];
      sctr_q[k+1] <= sctr_q[k];
      smag_q[k+1] <= smag_q[k];
      sneg_q[k+1] <= sneg_q[k];
    end
  end

  // ---------------- setup stage and CORDIC / divider chain ----------------
  logic               pv_q    [DivSteps+1];
  logic [31:0]        psc_q   [DivSteps+1][2];
  logic               pzero_q [DivSteps+1][2];   // scale is zero
  logic               pcnt0_q [DivSteps+1][2];   // pixel count is zero
  logic signed [31:0] pctr_q  [DivSteps+1][2];
  logic [5:0]         pk_q    [DivSteps+1][2];
  logic signed [43:0] px_q    [DivSteps+1][2];
  logic signed [43:0] py_q    [DivSteps+1][2];
  logic signed [34:0] pz_q    [DivSteps+1][2];
  logic [64:0]        pd_q    [DivSteps+1][2][3];
  logic [32:0]        prem_q  [DivSteps+1][2][3];
  logic [32:0]        pq_q    [DivSteps+1][2][3];
  logic               povf_q  [DivSteps+1][2][3];
  logic               pneg_q  [DivSteps+1][2][3];

  logic [31:0] scale_p [2];
  logic [15:0] cnt_p   [2];
  logic [33:0] or_p    [2];
  logic [5:0]  msb_p   [2];
  logic [64:0] dvd_p   [2][3];

  assign cnt_p[0] = cols_q;
  assign cnt_p[1] = rows_q;

  always_comb begin
    for (int s = 0; s < 2; s++) begin
      scale_p[s] = ssat_q[SqrtSteps][s] ? 32'hFFFFFFFF : sr_q[SqrtSteps][s][31:0];
      or_p[s]    = {1'b0, scale_p[s], 1'b0} | {2'b00, cnt_p[s], 16'd0};
      msb_p[s]   = '0;
      for (int b = 0; b < 34; b++) begin
        if (or_p[s][b]) msb_p[s] = 6'(b);
      end
      for (int j = 0; j < 3; j++) begin
        dvd_p[s][j] = 65'(smag_q[SqrtSteps][s][j]) + 65'(scale_p[s] >> 1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q[0] <= 1'b0;
    end else begin
      pv_q[0] <= sv_q[SqrtSteps];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int s = 0; s < 2; s++) begin
      psc_q[0][s]   <= scale_p[s];
      pzero_q[0][s] <= (scale_p[s] == '0);
      pcnt0_q[0][s] <= (cnt_p[s] == '0);
      pctr_q[0][s]  <= sctr_q[SqrtSteps][s];
      pk_q[0][s]    <= 6'(NormMsb) - msb_p[s];
      px_q[0][s]    <= 44'({scale_p[s], 1'b0});
      py_q[0][s]    <= 44'({cnt_p[s], 16'd0});
      pz_q[0][s]    <= '0;
      for (int j = 0; j < 3; j++) begin
        pd_q[0][s][j]   <= dvd_p[s][j];
        prem_q[0][s][j] <= {1'b0, dvd_p[s][j][64:33]};
        pq_q[0][s][j]   <= '0;
        povf_q[0][s][j] <= (dvd_p[s][j][64:33] >= scale_p[s]);
        pneg_q[0][s][j] <= sneg_q[SqrtSteps][s][j];
      end
    end
  end

  for (genvar t = 0; t < DivSteps; t++) begin : g_step
    logic [32:0] shl [2][3];

    always_comb begin
      for (int s = 0; s < 2; s++) begin
        for (int j = 0; j < 3; j++) begin
          shl[s][j] = {prem_q[t][s][j][31:0], pd_q[t][s][j][32-t]};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        pv_q[t+1] <= 1'b0;
      end else begin
        pv_q[t+1] <= pv_q[t];
      end
    end

    always_ff @(posedge clk_i) begin
      for (int s = 0; s < 2; s++) begin
        // one restoring division bit
        for (int j = 0; j < 3; j++) begin
          if (shl[s][j] >= {1'b0, psc_q[t][s]}) begin
            prem_q[t+1][s][j] <= shl[s][j] - {1'b0, psc_q[t][s]};
            pq_q[t+1][s][j]   <= {pq_q[t][s][j][31:0], 1'b1};
          end else begin
            prem_q[t+1][s][j] <= shl[s][j];
            pq_q[t+1][s][j]   <= {pq_q[t][s][j][31:0], 1'b0};
          end
        end
        if (t == 0) begin
          // normalize until the larger operand reaches 2^40
          px_q[t+1][s] <= px_q[t][s] <<< pk_q[t][s];
          py_q[t+1][s] <= py_q[t][s] <<< pk_q[t][s];
          pz_q[t+1][s] <= pz_q[t][s];
        end else if (py_q[t][s] > 0) begin
          px_q[t+1][s] <= px_q[t][s] + (py_q[t][s] >>> (t - 1));
          py_q[t+1][s] <= py_q[t][s] - (px_q[t][s] >>> (t - 1));
          pz_q[t+1][s] <= pz_q[t][s] + 35'(atan_step(t - 1));
        end else begin
          px_q[t+1][s] <= px_q[t][s] - (py_q[t][s] >>> (t - 1));
          py_q[t+1][s] <= py_q[t][s] + (px_q[t][s] >>> (t - 1));
          pz_q[t+1][s] <= pz_q[t][s] - 35'(atan_step(t - 1));
        end
      end
      psc_q[t+1]   <= psc_q[t];
      pzero_q[t+1] <= pzero_q[t];
      pcnt0_q[t+1] <= pcnt0_q[t];
      pctr_q[t+1]  <= pctr_q[t];
      pk_q[t+1]    <= pk_q[t];
      pd_q[t+1]    <= pd_q[t];
      povf_q[t+1]  <= povf_q[t];
      pneg_q[t+1]  <= pneg_q[t];
    end
  end

  // ---------------- output stage ----------------
  logic signed [34:0] zc     [2];
  logic [32:0]        zr     [2];
  logic [30:0]        fov_d  [2];
  logic signed [31:0] axis_d [2][3];

  always_comb begin
    for (int s = 0; s < 2; s++) begin
      zc[s] = pz_q[DivSteps][s][34] ? '0 : pz_q[DivSteps][s];
      zr[s] = 33'((zc[s] + 35'sd2) >>> 2);
      if (pcnt0_q[DivSteps][s]) begin
        fov_d[s] = '0;
      end else if (pzero_q[DivSteps][s] || zr[s] > 33'(PiQ329)) begin
        fov_d[s] = PiQ329;
      end else begin
        fov_d[s] = zr[s][30:0];
      end
      for (int j = 0; j < 3; j++) begin
        if (pzero_q[DivSteps][s]) begin
          axis_d[s][j] = '0;
        end else if (povf_q[DivSteps][s][j] || (|pq_q[DivSteps][s][j][32:31])) begin
          axis_d[s][j] = pneg_q[DivSteps][s][j] ? 32'sh80000000 : 32'sh7FFFFFFF;
        end else if (pneg_q[DivSteps][s][j]) begin
          axis_d[s][j] = -signed'(pq_q[DivSteps][s][j][31:0]);
        end else begin
          axis_d[s][j] = signed'(pq_q[DivSteps][s][j][31:0]);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o <= 1'b0;
    end else begin
      done_o <= pv_q[DivSteps];
    end
  end

  always_ff @(posedge clk_i) begin
    horiz_scale_o <= psc_q[DivSteps][0];
    vert_scale_o  <= psc_q[DivSteps][1];
    center_col_o  <= pctr_q[DivSteps][0];
    center_row_o  <= pctr_q[DivSteps][1];
    fov_horiz_o   <= fov_d[0];
    fov_vert_o    <= fov_d[1];
    plane_x_0_o   <= axis_d[0][0];
    plane_x_1_o   <= axis_d[0][1];
    plane_x_2_o   <= axis_d[0][2];
    plane_y_0_o   <= axis_d[1][0];
    plane_y_1_o   <= axis_d[1][1];
    plane_y_2_o   <= axis_d[1][2];
  end

  // ---------------- assertions ----------------
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##(Latency) done_o)
    else $error("request did not complete at the fixed latency");

  a_fov_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (fov_horiz_o <= PiQ329 && fov_vert_o <= PiQ329))
    else $error("field of view above pi");

  a_zero_scale: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && horiz_scale_o == '0) |->
      (plane_x_0_o == '0 && plane_x_1_o == '0 && plane_x_2_o == '0))
    else $error("zero scale with nonzero plane axis");

endmodule
